FILE: hw/rtl/ppps_pkg.sv
// ----------------------------------------------------------------------------
// ppps_pkg
// Shared types, register map and color decode for the planar palette
// pixel serializer.
// ----------------------------------------------------------------------------
package ppps_pkg;

    localparam int PLANE_W   = 8;
    localparam int IDX_W     = 4;
    localparam int ENTRY_W   = 6;
    localparam int PAL_W     = 48;
    localparam int CHAN_W    = 8;
    localparam int CNT_W     = 3;
    localparam int CFG_W     = 64;
    localparam int ADDR_W    = 5;

    // Register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_SHIFT_MODE   = 2'd0,
        REG_PALETTE_LOW  = 2'd1,
        REG_PALETTE_HIGH = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    // Shift mode codes
    localparam logic MODE_PLANAR = 1'b0;
    localparam logic MODE_PACKED = 1'b1;

    // Pixel counts per beat, minus one
    localparam logic [CNT_W-1:0] LAST_PLANAR = 3'd7;
    localparam logic [CNT_W-1:0] LAST_PACKED = 3'd3;

    // Channel levels
    localparam logic [CHAN_W-1:0] LEVEL_PRI = 8'hAA;
    localparam logic [CHAN_W-1:0] LEVEL_SEC = 8'h55;

    // Entry bit positions per channel
    localparam int BLUE_PRI  = 0;
    localparam int GREEN_PRI = 1;
    localparam int RED_PRI   = 2;
    localparam int BLUE_SEC  = 3;
    localparam int GREEN_SEC = 4;
    localparam int RED_SEC   = 5;

    // One palette index on its way out of the serializer
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } pix_t;

    // Decode one channel from a primary and a secondary bit
    function automatic logic [CHAN_W-1:0] chan_level(input logic pri, input logic sec);
        logic [CHAN_W-1:0] lvl;
        lvl = (pri ? LEVEL_PRI : '0) | (sec ? LEVEL_SEC : '0);
        return lvl;
    endfunction

endpackage

FILE: hw/rtl/ppps_serializer.sv
// ----------------------------------------------------------------------------
// ppps_serializer
// Holds one fetch of four plane bytes and shifts out one palette index per
// cycle while out_ready is high, MSB first: eight in planar, four in packed mode.
// ----------------------------------------------------------------------------
module ppps_serializer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_mode,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ppps_pkg::PLANE_W-1:0]  plane0,
    input  logic [ppps_pkg::PLANE_W-1:0]  plane1,
    input  logic [ppps_pkg::PLANE_W-1:0]  plane2,
    input  logic [ppps_pkg::PLANE_W-1:0]  plane3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ppps_pkg::pix_t                out_pix
);

    logic [ppps_pkg::PLANE_W-1:0] p0_reg, p0_next;
    logic [ppps_pkg::PLANE_W-1:0] p1_reg, p1_next;
    logic [ppps_pkg::PLANE_W-1:0] p2_reg, p2_next;
    logic [ppps_pkg::PLANE_W-1:0] p3_reg, p3_next;
    logic                         mode_reg, mode_next;
    logic [ppps_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         valid_reg, valid_next;
    logic                         is_last;
    logic                         advance;
    logic                         load;

    // Current pixel index and end-of-beat flag
    always_comb begin
        if (mode_reg == ppps_pkg::MODE_PACKED) begin
            out_pix.idx = {2'b00, p0_reg[7:6]};
            is_last     = (cnt_reg == ppps_pkg::LAST_PACKED);
        end else begin
            out_pix.idx = {p3_reg[7], p2_reg[7], p1_reg[7], p0_reg[7]};
            is_last     = (cnt_reg == ppps_pkg::LAST_PLANAR);
        end
        out_pix.last = is_last;
    end

    assign out_valid = valid_reg;
    assign advance   = valid_reg & out_ready;
    // Take the next beat while the final pixel of this one leaves
    assign in_ready  = ~valid_reg | (out_ready & is_last);
    assign load      = in_valid & in_ready;

    // Shift, count and reload
    always_comb begin
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        p3_next    = p3_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load) begin
            p0_next    = plane0;
            p1_next    = plane1;
            p2_next    = plane2;
            p3_next    = plane3;
            mode_next  = shift_mode;
            cnt_next   = '0;
            valid_next = 1'b1;
        end else if (advance) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
                if (mode_reg == ppps_pkg::MODE_PACKED) begin
                    p0_next = {p0_reg[5:0], 2'b00};
                end else begin
                    p0_next = {p0_reg[6:0], 1'b0};
                    p1_next = {p1_reg[6:0], 1'b0};
                    p2_next = {p2_reg[6:0], 1'b0};
                    p3_next = {p3_reg[6:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            mode_reg  <= ppps_pkg::MODE_PLANAR;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        p3_reg <= p3_next;
    end

endmodule

FILE: hw/rtl/planar_palette_pixel_serializer.sv
// ----------------------------------------------------------------------------
// planar_palette_pixel_serializer
// Turns four-plane display fetches into a stream of 24-bit RGB pixels
// through a sixteen-entry, 6-bit palette.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat is one fetch, four plane bytes. In planar mode it
//   yields eight pixels, in packed 2-bit mode four (from plane 0 only).
//   m_ channel: one beat per pixel, red/green/blue in tdata, tlast on the
//   final pixel of each fetch.
//   APB port: shift_mode at 0x00, palette_low at 0x08, palette_high at 0x10;
//   write only while the stream is idle.
// Timing:
//   Three register stages: serializer, palette lookup, color decode. The
//   first pixel of a fetch goes from the serializer registers through the
//   lookup register into the output register; back-pressure can hold it.
//   The serializer emits one pixel per cycle while the lookup stage accepts,
//   giving eight pixels per fetch in planar mode and four in packed mode;
//   the next fetch is taken in the cycle the final pixel of the last one leaves.
// Reset clears all stage valids and the configuration registers to zero.
// If m_tready is low, only stages with room move; no pixel is dropped or repeated.
// ----------------------------------------------------------------------------
module planar_palette_pixel_serializer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Fetch input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // plane0, plane1, plane2, plane3
    // Pixel output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,  // red, green, blue
    output logic                          m_tlast,
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppps_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppps_pkg::CFG_W-1:0]    pwdata,
    output logic [ppps_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);

    logic                          shift_mode_reg;
    logic [ppps_pkg::PAL_W-1:0]    pal_low_reg;
    logic [ppps_pkg::PAL_W-1:0]    pal_high_reg;
    ppps_pkg::reg_idx_t            reg_idx;
    logic                          cfg_wr;

    logic                          ser_valid;
    logic                          ser_ready;
    ppps_pkg::pix_t                ser_pix;

    logic                          lk_valid_reg;
    logic [ppps_pkg::ENTRY_W-1:0]  lk_entry_reg;
    logic                          lk_last_reg;
    logic                          lk_ready;
    logic [ppps_pkg::PAL_W-1:0]    bank;
    logic [ppps_pkg::ENTRY_W-1:0]  entry_next;

    logic                          out_valid_reg;
    logic [23:0]                   out_data_reg;
    logic                          out_last_reg;
    logic                          out_ready;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = ppps_pkg::reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_mode_reg <= ppps_pkg::MODE_PLANAR;
            pal_low_reg    <= '0;
            pal_high_reg   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                ppps_pkg::REG_SHIFT_MODE:   shift_mode_reg <= pwdata[0];
                ppps_pkg::REG_PALETTE_LOW:  pal_low_reg    <= pwdata[ppps_pkg::PAL_W-1:0];
                ppps_pkg::REG_PALETTE_HIGH: pal_high_reg   <= pwdata[ppps_pkg::PAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ppps_pkg::REG_SHIFT_MODE:   prdata = {{(ppps_pkg::CFG_W-1){1'b0}}, shift_mode_reg};
            ppps_pkg::REG_PALETTE_LOW:
                prdata = {{(ppps_pkg::CFG_W-ppps_pkg::PAL_W){1'b0}}, pal_low_reg};
            ppps_pkg::REG_PALETTE_HIGH:
                prdata = {{(ppps_pkg::CFG_W-ppps_pkg::PAL_W){1'b0}}, pal_high_reg};
            default:                    prdata = '0;
        endcase
    end

    // Stage 1: serialize fetch into palette indices
    ppps_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_mode (shift_mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .plane0     (s_tdata[7:0]),
        .plane1     (s_tdata[15:8]),
        .plane2     (s_tdata[23:16]),
        .plane3     (s_tdata[31:24]),
        .out_valid  (ser_valid),
        .out_ready  (ser_ready),
        .out_pix    (ser_pix)
    );

    assign out_ready = ~out_valid_reg | m_tready;
    assign lk_ready  = ~lk_valid_reg | out_ready;
    assign ser_ready = lk_ready;

    // Stage 2: palette lookup
    assign bank       = ser_pix.idx[3] ? pal_high_reg : pal_low_reg;
    assign entry_next = bank[ser_pix.idx[2:0]*ppps_pkg::ENTRY_W +: ppps_pkg::ENTRY_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lk_valid_reg <= 1'b0;
        end else if (lk_ready) begin
            lk_valid_reg <= ser_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (lk_ready) begin
            lk_entry_reg <= entry_next;
            lk_last_reg  <= ser_pix.last;
        end
    end

    // Stage 3: decode entry into channel levels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= lk_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_data_reg[7:0]   <= ppps_pkg::chan_level(lk_entry_reg[ppps_pkg::RED_PRI],
                                                        lk_entry_reg[ppps_pkg::RED_SEC]);
            out_data_reg[15:8]  <= ppps_pkg::chan_level(lk_entry_reg[ppps_pkg::GREEN_PRI],
                                                        lk_entry_reg[ppps_pkg::GREEN_SEC]);
            out_data_reg[23:16] <= ppps_pkg::chan_level(lk_entry_reg[ppps_pkg::BLUE_PRI],
                                                        lk_entry_reg[ppps_pkg::BLUE_SEC]);
            out_last_reg        <= lk_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams display fetches into the planar palette pixel serializer under
// random source gaps and sink stalls, and checks every RGB pixel against a
// palette and color decode model kept here. Registers are reprogrammed over
// APB between phases, covering planar and packed mode and extreme palettes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_FETCHES = 212;
    localparam int MAX_GAP = 12;

    // One fetch beat, plane 0 in the lowest byte
    typedef struct packed {
        logic [ppps_pkg::PLANE_W-1:0] plane3;
        logic [ppps_pkg::PLANE_W-1:0] plane2;
        logic [ppps_pkg::PLANE_W-1:0] plane1;
        logic [ppps_pkg::PLANE_W-1:0] plane0;
    } fetch_t;

    // One expected pixel
    typedef struct {
        logic [ppps_pkg::CHAN_W-1:0] red;
        logic [ppps_pkg::CHAN_W-1:0] green;
        logic [ppps_pkg::CHAN_W-1:0] blue;
        logic                        last;
    } pixel_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [31:0]                   s_tdata = '0;  // plane0, plane1, plane2, plane3
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [23:0]                   m_tdata;       // red, green, blue
    logic                          m_tlast;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ppps_pkg::ADDR_W-1:0]   paddr = '0;
    logic [ppps_pkg::CFG_W-1:0]    pwdata = '0;
    logic [ppps_pkg::CFG_W-1:0]    prdata;
    logic                          pready;

    // Register shadow used for prediction
    logic                          mode_sel = ppps_pkg::MODE_PLANAR;
    logic [ppps_pkg::PAL_W-1:0]    pal_lo = '0;
    logic [ppps_pkg::PAL_W-1:0]    pal_hi = '0;

    fetch_t              fetch_q[$];
    pixel_t              pixel_q[$];
    int                  s_gap = 0;
    int                  m_stall = 0;
    bit                  s_gaps_on = 1'b1;
    bit                  m_stalls_on = 1'b1;
    logic                s_beat_taken = 1'b0;
    logic                m_beat_taken = 1'b0;
    int                  cycle_count = 0;
    int                  error_count = 0;

    planar_palette_pixel_serializer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Decode one channel: primary bit weighs 0xAA, secondary 0x55
    function automatic logic [ppps_pkg::CHAN_W-1:0] level(input logic pri, input logic sec);
        return (pri ? ppps_pkg::LEVEL_PRI : 8'h00) + (sec ? ppps_pkg::LEVEL_SEC : 8'h00);
    endfunction

    // Look up a palette index and decode its entry to RGB
    function automatic pixel_t color_of(input logic [ppps_pkg::IDX_W-1:0] idx,
                                        input logic last);
        logic [ppps_pkg::PAL_W-1:0]   bank;
        logic [ppps_pkg::ENTRY_W-1:0] entry;
        pixel_t                       p;
        bank = idx[3] ? pal_hi : pal_lo;
        entry = bank[idx[2:0]*ppps_pkg::ENTRY_W +: ppps_pkg::ENTRY_W];
        p.red = level(entry[ppps_pkg::RED_PRI], entry[ppps_pkg::RED_SEC]);
        p.green = level(entry[ppps_pkg::GREEN_PRI], entry[ppps_pkg::GREEN_SEC]);
        p.blue = level(entry[ppps_pkg::BLUE_PRI], entry[ppps_pkg::BLUE_SEC]);
        p.last = last;
        return p;
    endfunction

    // Expand one accepted fetch into its pixels, leftmost first
    task automatic predict_pixels(input fetch_t f);
        logic [ppps_pkg::IDX_W-1:0] idx;
        if (mode_sel == ppps_pkg::MODE_PACKED) begin
            for (int k = 0; k < 4; k++) begin
                idx = {2'b00, f.plane0[6-2*k +: 2]};
                pixel_q.push_back(color_of(idx, k == 3));
            end
        end else begin
            for (int k = 0; k < 8; k++) begin
                idx = {f.plane3[7-k], f.plane2[7-k], f.plane1[7-k], f.plane0[7-k]};
                pixel_q.push_back(color_of(idx, k == 7));
            end
        end
    endtask

    // APB write: setup, access, then mirror the masked value into the shadow
    task automatic reg_write(input ppps_pkg::reg_idx_t r, input logic [ppps_pkg::CFG_W-1:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 3'b000};
        pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            ppps_pkg::REG_SHIFT_MODE:   mode_sel = v[0];
            ppps_pkg::REG_PALETTE_LOW:  pal_lo = v[ppps_pkg::PAL_W-1:0];
            ppps_pkg::REG_PALETTE_HIGH: pal_hi = v[ppps_pkg::PAL_W-1:0];
            default: ;
        endcase
    endtask

    // Block until every queued fetch is sent and every pixel has come back;
    // look at the rising edge, where the source outputs are settled
    task automatic wait_drained();
        do @(posedge aclk);
        while (fetch_q.size() != 0 || s_tvalid || pixel_q.size() != 0);
    endtask

    // Pick a palette bank value, extremes included
    function automatic logic [ppps_pkg::CFG_W-1:0] pick_palette();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Source: present queued fetches, with a random gap before each
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat_taken) begin
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (fetch_q.size() != 0) begin
                s_tdata <= fetch_q.pop_front();
                s_tvalid <= 1'b1;
                s_gap <= s_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink: after each pixel beat, stall for a random number of cycles
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_beat_taken)
                m_stall = m_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (m_stall > 0) begin
                m_tready <= 1'b0;
                m_stall = m_stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Predict on accepted fetches, check accepted pixels, guard the run length
    always @(posedge aclk) begin
        pixel_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            s_beat_taken <= aresetn && s_tvalid && s_tready;
            m_beat_taken <= aresetn && m_tvalid && m_tready;
            if (aresetn && s_tvalid && s_tready)
                predict_pixels(fetch_t'(s_tdata));
            if (aresetn && m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    $error("unexpected pixel: tdata %h, tlast %b", m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata[7:0] !== want.red) begin
                        $error("red: expected %h, got %h", want.red, m_tdata[7:0]);
                        error_count++;
                    end
                    if (m_tdata[15:8] !== want.green) begin
                        $error("green: expected %h, got %h", want.green, m_tdata[15:8]);
                        error_count++;
                    end
                    if (m_tdata[23:16] !== want.blue) begin
                        $error("blue: expected %h, got %h", want.blue, m_tdata[23:16]);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_pixel: expected %b, got %b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus: directed phases first, then random phases
    initial begin
        fetch_t f;
        int     sent;
        int     count;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset palette is all zero: everything comes out black
        fetch_q.push_back(32'h0000_0000);
        fetch_q.push_back(32'hFFFF_FFFF);
        wait_drained();

        // Low bank: one-bit entries plus all and none; high bank: mixed levels;
        // junk above bit 47 and above bit 0 must be dropped
        reg_write(ppps_pkg::REG_PALETTE_LOW,
                  {16'hFFFF, 6'h20, 6'h04, 6'h10, 6'h02, 6'h08, 6'h01, 6'h3F, 6'h00});
        reg_write(ppps_pkg::REG_PALETTE_HIGH,
                  {16'hA5A5, 6'h2A, 6'h15, 6'h1B, 6'h2D, 6'h36, 6'h24, 6'h12, 6'h09});
        reg_write(ppps_pkg::REG_SHIFT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);

        // Planar: each plane alone, all and none, then all sixteen indices
        fetch_q.push_back(32'h0000_00FF);
        fetch_q.push_back(32'h0000_FF00);
        fetch_q.push_back(32'h00FF_0000);
        fetch_q.push_back(32'hFF00_0000);
        fetch_q.push_back(32'hFFFF_FFFF);
        fetch_q.push_back(32'h0000_0000);
        fetch_q.push_back(32'hF0CC_AA00);
        fetch_q.push_back(32'h0F33_55FF);
        wait_drained();

        // Writes to the unused slot leave the map alone
        reg_write(ppps_pkg::REG_UNUSED, '1);
        reg_write(ppps_pkg::REG_SHIFT_MODE, 64'h8000_0000_0000_0003);

        // Packed: indices from plane 0 only, other planes are noise
        fetch_q.push_back(32'h0000_001B);
        fetch_q.push_back(32'hFFFF_FFE4);
        fetch_q.push_back(32'hA5C3_3C00);
        fetch_q.push_back(32'h0000_00FF);
        fetch_q.push_back(32'h1234_5655);
        fetch_q.push_back(32'hFFFF_FF00);
        wait_drained();

        // Saturated palette, back to planar
        reg_write(ppps_pkg::REG_PALETTE_LOW, '1);
        reg_write(ppps_pkg::REG_PALETTE_HIGH, '1);
        reg_write(ppps_pkg::REG_SHIFT_MODE, '0);
        fetch_q.push_back(32'h0F0F_F0F0);
        fetch_q.push_back(32'h8001_4002);
        wait_drained();

        // Random phases: fresh settings, then a burst of random fetches
        sent = 0;
        while (sent < RANDOM_FETCHES) begin
            if ($urandom_range(0, 7) == 0)
                reg_write(ppps_pkg::REG_UNUSED, {$urandom(), $urandom()});
            reg_write(ppps_pkg::REG_SHIFT_MODE, {$urandom(), $urandom()});
            if ($urandom_range(0, 3) != 0)
                reg_write(ppps_pkg::REG_PALETTE_LOW, pick_palette());
            if ($urandom_range(0, 3) != 0)
                reg_write(ppps_pkg::REG_PALETTE_HIGH, pick_palette());
            s_gaps_on = ($urandom_range(0, 3) != 0);
            m_stalls_on = ($urandom_range(0, 3) != 0);
            count = $urandom_range(15, 40);
            if (count > RANDOM_FETCHES - sent)
                count = RANDOM_FETCHES - sent;
            for (int n = 0; n < count; n++) begin
                f = {$urandom()};
                // Bias some planes to all zeros or all ones
                if ($urandom_range(0, 7) == 0) f.plane0 = '0;
                if ($urandom_range(0, 7) == 0) f.plane1 = '1;
                if ($urandom_range(0, 7) == 0) f.plane2 = '0;
                if ($urandom_range(0, 7) == 0) f.plane3 = '1;
                fetch_q.push_back(f);
            end
            sent += count;
            wait_drained();
        end

        // Let any stray pixel show up before the verdict
        repeat (24) @(posedge aclk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
